FILE: rtl/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

  localparam int unsigned COMP_W    = 32;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned DIM       = 4;
  localparam int unsigned ENTRIES   = DIM * DIM;

  typedef logic [COMP_W-1:0] comp_t;
  typedef comp_t [ENTRIES-1:0] matrix_t;
  typedef comp_t [DIM-1:0] vec_t;

  // Register file after reset: identity matrix.
  localparam logic [REG_COUNT-1:0][REG_W-1:0] REG_RESET = {
    64'h0000_0001_0000_0000,  // w_coeff_second
    64'h0000_0000_0000_0000,  // w_coeff_first
    64'h0000_0000_0000_0001,  // z_coeff_second
    64'h0000_0000_0000_0000,  // z_coeff_first
    64'h0000_0000_0000_0000,  // y_coeff_second
    64'h0000_0001_0000_0000,  // y_coeff_first
    64'h0000_0000_0000_0000,  // x_coeff_second
    64'h0000_0000_0000_0001   // x_coeff_first
  };

  typedef struct packed {
    logic signed [COMP_W-1:0] in_w;
    logic signed [COMP_W-1:0] in_z;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_x;
  } in_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_w;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_x;
  } out_word_t;

endpackage

FILE: rtl/matrix_vector_transform_top.sv
// Top level of the 4x4 integer matrix-vector transform.
// Takes one signed 32-bit four-component vector per cycle and returns it multiplied by the
// configured 4x4 matrix, each component wrapped to 32 bits. Throughput is one word per clock
// when nothing stalls; latency is four register stages (input capture, sixteen parallel 32x32
// products, pairwise sums, final sums). Backpressure from out_ready stalls the stages in place
// without loss. The matrix is eight 64-bit registers, two entries each in column order, written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the pipeline is empty,
// which the block does not enforce. Reset loads the identity.
module matrix_vector_transform_top
  import mvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_word
);

  matrix_t matrix;

  mvt_coeff_regs u_coeff_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .matrix    (matrix)
  );

  mvt_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .matrix    (matrix),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/mvt_coeff_regs.sv
// Coefficient register file: eight 64-bit registers unpacked into 16 matrix entries.
module mvt_coeff_regs
  import mvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  output matrix_t                matrix
);

  logic [REG_COUNT-1:0][REG_W-1:0] regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // entry 2k in low half of register k, entry 2k+1 in high half
  for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
    assign matrix[e] = regs[e / 2][(e % 2) * COMP_W +: COMP_W];
  end

endmodule

FILE: rtl/mvt_pipe.sv
// Four-stage multiply and add pipeline with per-stage valid and backpressure.
module mvt_pipe
  import mvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  matrix_t   matrix,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  vec_t                 vec1;
  comp_t [DIM-1:0][DIM-1:0] prod2;   // [column][row]
  comp_t [DIM-1:0][1:0]     part3;   // [row][half]
  vec_t                 sum4;

  vec_t                     prod_next_vec;
  comp_t [DIM-1:0][DIM-1:0] prod_next;
  comp_t [DIM-1:0][1:0]     part_next;
  vec_t                     sum_next;

  assign adv4     = !v4 || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign prod_next_vec = vec1;

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        prod_next[c][r] = COMP_W'(matrix[DIM * c + r] * prod_next_vec[c]);
      end
    end
    for (int r = 0; r < DIM; r++) begin
      part_next[r][0] = prod2[0][r] + prod2[1][r];
      part_next[r][1] = prod2[2][r] + prod2[3][r];
      sum_next[r]     = part3[r][0] + part3[r][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      vec1 <= {in_word.in_w, in_word.in_z, in_word.in_y, in_word.in_x};
    end
    if (adv2 && v1) prod2 <= prod_next;
    if (adv3 && v2) part3 <= part_next;
    if (adv4 && v3) sum4  <= sum_next;
  end

  assign out_valid      = v4;
  assign out_word.out_x = sum4[0];
  assign out_word.out_y = sum4[1];
  assign out_word.out_z = sum4[2];
  assign out_word.out_w = sum4[3];

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!v1 || !v2 || !v3 || !v4 || out_ready))
    else $error("input ready disagrees with pipeline occupancy");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !v3 |=> !out_valid)
    else $error("word appeared at output with nothing behind it");

  a_stall_keeps_s2: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv2 |=> v2 && $stable(prod2))
    else $error("product stage lost or changed a stalled word");

  a_stall_keeps_s3: assert property (@(posedge clk) disable iff (rst)
    v3 && !adv3 |=> v3 && $stable(part3))
    else $error("partial sum stage lost or changed a stalled word");

endmodule
